// ===== hw/rtl/qtt_pkg.sv =====
// Types, constants and character classes for the query text tokenizer.
package qtt_pkg;

   localparam int OffsetWidth = 16;
   localparam int MaxRes = 2;

   localparam logic [2:0] KIND_IDENT = 3'd0;
   localparam logic [2:0] KIND_STR = 3'd1;
   localparam logic [2:0] KIND_NUM = 3'd2;
   localparam logic [2:0] KIND_SYM = 3'd3;
   localparam logic [2:0] KIND_END = 3'd4;
   localparam logic [2:0] KIND_ERR = 3'd5;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_CHAR = 2'd1;
   localparam logic [1:0] ERR_STRING = 2'd2;
   localparam logic [1:0] ERR_COMMENT = 2'd3;

   localparam logic ACTION_CHAR = 1'b0;
   localparam logic ACTION_END = 1'b1;

   typedef enum logic [14:0] {
      MODE_IDLE = 15'b000000000000001,
      MODE_IDENT = 15'b000000000000010,
      MODE_NINT = 15'b000000000000100,
      MODE_NFRAC = 15'b000000000001000,
      MODE_NEXP = 15'b000000000010000,
      MODE_NEXPD = 15'b000000000100000,
      MODE_STR = 15'b000000001000000,
      MODE_STRESC = 15'b000000010000000,
      MODE_LINE = 15'b000000100000000,
      MODE_BLOCK = 15'b000001000000000,
      MODE_BSTAR = 15'b000010000000000,
      MODE_PSLASH = 15'b000100000000000,
      MODE_PMINUS = 15'b001000000000000,
      MODE_PSYM = 15'b010000000000000,
      MODE_ERR = 15'b100000000000000
   } mode_type;

   typedef struct packed {
      logic [2:0] token_kind;
      logic [7:0] data_byte;
      logic has_data;
      logic token_first;
      logic token_last;
      logic [15:0] token_offset;
      logic [1:0] error_code;
      logic run_last;
   } item_type;

   function automatic item_type make_item(logic [2:0] kind, logic [7:0] data, logic has,
                                          logic first, logic last,
                                          logic [OffsetWidth-1:0] off, logic [1:0] err);
      item_type r;
      begin
         r.token_kind = kind;
         r.data_byte = has ? data : 8'd0;
         r.has_data = has;
         r.token_first = first;
         r.token_last = last;
         r.token_offset = 16'(off);
         r.error_code = err;
         r.run_last = 1'b0;
         return r;
      end
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == " ") || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_word(logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == "_";
   endfunction

   function automatic logic is_single(logic [7:0] c);
      return c == "(" || c == ")" || c == "{" || c == "}" || c == "[" || c == "]" ||
             c == ";" || c == "," || c == "." || c == "=" || c == "!" || c == "<" ||
             c == ">" || c == ":" || c == "+";
   endfunction

   function automatic logic is_pair_start(logic [7:0] c);
      return c == "=" || c == "!" || c == "<" || c == ">" || c == "&" || c == "|";
   endfunction

   function automatic logic is_pair(logic [7:0] a, logic [7:0] b);
      return (a == "=" && b == ">") || (a == "=" && b == "=") ||
             (a == "!" && b == "=") || (a == "<" && b == "=") ||
             (a == ">" && b == "=") || (a == "&" && b == "&") ||
             (a == "|" && b == "|") || (a == "<" && b == ">");
   endfunction

   function automatic logic [7:0] unescape(logic [7:0] c);
      logic [7:0] r;
      begin
         case (c)
            "n": r = 8'd10;
            "r": r = 8'd13;
            "t": r = 8'd9;
            default: r = c;
         endcase
         return r;
      end
   endfunction

   // Next number mode if c continues the number, else idle.
   function automatic mode_type num_next(mode_type m, logic [7:0] c);
      logic d;
      logic e;
      mode_type r;
      begin
         d = is_digit(c);
         e = (c == "e") || (c == "E");
         r = MODE_IDLE;
         case (m)
            MODE_NINT: begin
               if (d) r = MODE_NINT;
               else if (c == ".") r = MODE_NFRAC;
               else if (e) r = MODE_NEXP;
            end
            MODE_NFRAC: begin
               if (d) r = MODE_NFRAC;
               else if (e) r = MODE_NEXP;
            end
            MODE_NEXP: begin
               if (d || c == "+" || c == "-") r = MODE_NEXPD;
            end
            default: begin
               if (d) r = MODE_NEXPD;
            end
         endcase
         return r;
      end
   endfunction

endpackage

// ===== hw/rtl/qtt_if.sv =====
// Handshake channels for tokenizer input bytes and token results.
interface qtt_req_if;
   logic valid;
   logic ready;
   logic action;
   logic [7:0] char_in;

   modport source (output valid, output action, output char_in, input ready);
   modport sink (input valid, input action, input char_in, output ready);
endinterface

interface qtt_rsp_if;
   logic valid;
   logic ready;
   logic [2:0] token_kind;
   logic [7:0] data_byte;
   logic has_data;
   logic token_first;
   logic token_last;
   logic [15:0] token_offset;
   logic [1:0] error_code;
   logic run_last;

   modport source (output valid, output token_kind, output data_byte, output has_data,
                   output token_first, output token_last, output token_offset,
                   output error_code, output run_last, input ready);
   modport sink (input valid, input token_kind, input data_byte, input has_data,
                 input token_first, input token_last, input token_offset,
                 input error_code, input run_last, output ready);
endinterface

// ===== hw/rtl/query_text_tokenizer_top.sv =====
// Streaming lexer for query text: bytes in, token items out.
//
//   channel   direction  handshake            payload
//   req_ch    in         valid/ready          action, char_in
//   rsp_ch    out        valid/ready          token item, run_last
//
// A byte is taken while req_ch.ready is high; its results (zero, one or two items) land
// in a two-entry result buffer at the next edge and leave one per cycle while rsp_ch.ready
// is high. A new byte is taken while the buffer is empty or its last item transfers that
// cycle, so one-result bytes sustain one per cycle; a two-result byte holds off the next.
// Synchronous reset returns the lexer to idle with offset zero and empties the buffer.
module query_text_tokenizer_top (
   input logic clock,
   input logic reset,
   qtt_req_if.sink req_ch,
   qtt_rsp_if.source rsp_ch
);

   localparam int OW = qtt_pkg::OffsetWidth;
   localparam logic [OW-1:0] PosMax = '1;

   qtt_pkg::mode_type mode_ff, mode_in;
   logic [7:0] held_byte_ff, held_byte_in;
   logic held_valid_ff, held_valid_in;
   logic held_first_ff, held_first_in;
   logic [2:0] held_kind_ff, held_kind_in;
   logic [OW-1:0] token_start_ff, token_start_in;
   logic [OW-1:0] pos_ff, pos_in;
   logic quote_double_ff, quote_double_in;

   qtt_pkg::item_type res [qtt_pkg::MaxRes];
   logic [1:0] res_cnt;
   logic do_start;
   logic [7:0] c;

   qtt_pkg::item_type buf_ff [qtt_pkg::MaxRes];
   qtt_pkg::item_type buf_in [qtt_pkg::MaxRes];
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, rd_in;
   logic accept, pop;

   assign c = req_ch.char_in;

   always_comb begin
      mode_in = mode_ff;
      held_byte_in = held_byte_ff;
      held_valid_in = held_valid_ff;
      held_first_in = held_first_ff;
      held_kind_in = held_kind_ff;
      token_start_in = token_start_ff;
      pos_in = pos_ff;
      quote_double_in = quote_double_ff;
      res[0] = '0;
      res[1] = '0;
      res_cnt = 2'd0;
      do_start = 1'b0;

      if (req_ch.action == qtt_pkg::ACTION_END) begin
         unique case (mode_ff) inside
            qtt_pkg::MODE_IDENT, qtt_pkg::MODE_NINT, qtt_pkg::MODE_NFRAC,
            qtt_pkg::MODE_NEXP, qtt_pkg::MODE_NEXPD: begin
               res[0] = qtt_pkg::make_item(held_kind_ff, held_byte_ff, 1'b1, held_first_ff,
                                           1'b1, token_start_ff, qtt_pkg::ERR_NONE);
               res[1] = qtt_pkg::make_item(qtt_pkg::KIND_END, 8'd0, 1'b0, 1'b1, 1'b1,
                                           pos_ff, qtt_pkg::ERR_NONE);
               res_cnt = 2'd2;
            end
            qtt_pkg::MODE_STR, qtt_pkg::MODE_STRESC: begin
               res[0] = qtt_pkg::make_item(qtt_pkg::KIND_ERR, 8'd0, 1'b0, 1'b1, 1'b1,
                                           token_start_ff, qtt_pkg::ERR_STRING);
               res_cnt = 2'd1;
            end
            qtt_pkg::MODE_BLOCK, qtt_pkg::MODE_BSTAR: begin
               res[0] = qtt_pkg::make_item(qtt_pkg::KIND_ERR, 8'd0, 1'b0, 1'b1, 1'b1,
                                           token_start_ff, qtt_pkg::ERR_COMMENT);
               res_cnt = 2'd1;
            end
            qtt_pkg::MODE_PSLASH, qtt_pkg::MODE_PMINUS: begin
               res[0] = qtt_pkg::make_item(qtt_pkg::KIND_ERR, 8'd0, 1'b0, 1'b1, 1'b1,
                                           token_start_ff, qtt_pkg::ERR_CHAR);
               res_cnt = 2'd1;
            end
            qtt_pkg::MODE_PSYM: begin
               if (qtt_pkg::is_single(held_byte_ff)) begin
                  res[0] = qtt_pkg::make_item(held_kind_ff, held_byte_ff, 1'b1,
                                              held_first_ff, 1'b1, token_start_ff,
                                              qtt_pkg::ERR_NONE);
                  res[1] = qtt_pkg::make_item(qtt_pkg::KIND_END, 8'd0, 1'b0, 1'b1, 1'b1,
                                              pos_ff, qtt_pkg::ERR_NONE);
                  res_cnt = 2'd2;
               end else begin
                  res[0] = qtt_pkg::make_item(qtt_pkg::KIND_ERR, 8'd0, 1'b0, 1'b1, 1'b1,
                                              token_start_ff, qtt_pkg::ERR_CHAR);
                  res_cnt = 2'd1;
               end
            end
            qtt_pkg::MODE_IDLE, qtt_pkg::MODE_LINE: begin
               res[0] = qtt_pkg::make_item(qtt_pkg::KIND_END, 8'd0, 1'b0, 1'b1, 1'b1,
                                           pos_ff, qtt_pkg::ERR_NONE);
               res_cnt = 2'd1;
            end
            qtt_pkg::MODE_ERR: begin
            end
            default: begin
            end
         endcase
         mode_in = qtt_pkg::MODE_IDLE;
         held_byte_in = 8'd0;
         held_valid_in = 1'b0;
         held_first_in = 1'b0;
         held_kind_in = 3'd0;
         token_start_in = '0;
         pos_in = '0;
         quote_double_in = 1'b0;
      end else begin
         unique case (mode_ff) inside
            qtt_pkg::MODE_IDLE: begin
               do_start = 1'b1;
            end
            qtt_pkg::MODE_IDENT: begin
               if (qtt_pkg::is_word(c)) begin
                  if (held_valid_ff) begin
                     res[0] = qtt_pkg::make_item(held_kind_ff, held_byte_ff, 1'b1,
                                                 held_first_ff, 1'b0, token_start_ff,
                                                 qtt_pkg::ERR_NONE);
                     res_cnt = 2'd1;
                     held_first_in = 1'b0;
                  end
                  held_byte_in = c;
                  held_valid_in = 1'b1;
               end else begin
                  res[0] = qtt_pkg::make_item(held_kind_ff, held_byte_ff, 1'b1,
                                              held_first_ff, 1'b1, token_start_ff,
                                              qtt_pkg::ERR_NONE);
                  res_cnt = 2'd1;
                  held_first_in = 1'b0;
                  held_valid_in = 1'b0;
                  do_start = 1'b1;
               end
            end
            qtt_pkg::MODE_NINT, qtt_pkg::MODE_NFRAC, qtt_pkg::MODE_NEXP,
            qtt_pkg::MODE_NEXPD: begin
               if (qtt_pkg::num_next(mode_ff, c) != qtt_pkg::MODE_IDLE) begin
                  if (held_valid_ff) begin
                     res[0] = qtt_pkg::make_item(held_kind_ff, held_byte_ff, 1'b1,
                                                 held_first_ff, 1'b0, token_start_ff,
                                                 qtt_pkg::ERR_NONE);
                     res_cnt = 2'd1;
                     held_first_in = 1'b0;
                  end
                  held_byte_in = c;
                  held_valid_in = 1'b1;
                  mode_in = qtt_pkg::num_next(mode_ff, c);
               end else begin
                  res[0] = qtt_pkg::make_item(held_kind_ff, held_byte_ff, 1'b1,
                                              held_first_ff, 1'b1, token_start_ff,
                                              qtt_pkg::ERR_NONE);
                  res_cnt = 2'd1;
                  held_first_in = 1'b0;
                  held_valid_in = 1'b0;
                  do_start = 1'b1;
               end
            end
            qtt_pkg::MODE_STR: begin
               if (c == (quote_double_ff ? 8'h22 : 8'h27)) begin
                  if (held_valid_ff) begin
                     res[0] = qtt_pkg::make_item(held_kind_ff, held_byte_ff, 1'b1,
                                                 held_first_ff, 1'b1, token_start_ff,
                                                 qtt_pkg::ERR_NONE);
                     held_first_in = 1'b0;
                  end else begin
                     res[0] = qtt_pkg::make_item(qtt_pkg::KIND_STR, 8'd0, 1'b0, 1'b1, 1'b1,
                                                 token_start_ff, qtt_pkg::ERR_NONE);
                  end
                  res_cnt = 2'd1;
                  held_valid_in = 1'b0;
                  mode_in = qtt_pkg::MODE_IDLE;
               end else if (c == 8'h5C) begin
                  mode_in = qtt_pkg::MODE_STRESC;
               end else begin
                  if (held_valid_ff) begin
                     res[0] = qtt_pkg::make_item(held_kind_ff, held_byte_ff, 1'b1,
                                                 held_first_ff, 1'b0, token_start_ff,
                                                 qtt_pkg::ERR_NONE);
                     res_cnt = 2'd1;
                     held_first_in = 1'b0;
                  end
                  held_byte_in = c;
                  held_valid_in = 1'b1;
               end
            end
            qtt_pkg::MODE_STRESC: begin
               if (held_valid_ff) begin
                  res[0] = qtt_pkg::make_item(held_kind_ff, held_byte_ff, 1'b1,
                                              held_first_ff, 1'b0, token_start_ff,
                                              qtt_pkg::ERR_NONE);
                  res_cnt = 2'd1;
                  held_first_in = 1'b0;
               end
               held_byte_in = qtt_pkg::unescape(c);
               held_valid_in = 1'b1;
               mode_in = qtt_pkg::MODE_STR;
            end
            qtt_pkg::MODE_LINE: begin
               if (c == 8'd10) mode_in = qtt_pkg::MODE_IDLE;
            end
            qtt_pkg::MODE_BLOCK: begin
               if (c == "*") mode_in = qtt_pkg::MODE_BSTAR;
            end
            qtt_pkg::MODE_BSTAR: begin
               if (c == "/") mode_in = qtt_pkg::MODE_IDLE;
               else if (c != "*") mode_in = qtt_pkg::MODE_BLOCK;
            end
            qtt_pkg::MODE_PSLASH: begin
               if (c == "/") begin
                  mode_in = qtt_pkg::MODE_LINE;
               end else if (c == "*") begin
                  mode_in = qtt_pkg::MODE_BLOCK;
               end else begin
                  res[0] = qtt_pkg::make_item(qtt_pkg::KIND_ERR, 8'd0, 1'b0, 1'b1, 1'b1,
                                              token_start_ff, qtt_pkg::ERR_CHAR);
                  res_cnt = 2'd1;
                  held_valid_in = 1'b0;
                  mode_in = qtt_pkg::MODE_ERR;
               end
            end
            qtt_pkg::MODE_PMINUS: begin
               if (c == "-") begin
                  mode_in = qtt_pkg::MODE_LINE;
               end else if (qtt_pkg::is_digit(c)) begin
                  res[0] = qtt_pkg::make_item(qtt_pkg::KIND_NUM, "-", 1'b1, 1'b1, 1'b0,
                                              token_start_ff, qtt_pkg::ERR_NONE);
                  res_cnt = 2'd1;
                  held_byte_in = c;
                  held_valid_in = 1'b1;
                  held_first_in = 1'b0;
                  held_kind_in = qtt_pkg::KIND_NUM;
                  mode_in = qtt_pkg::MODE_NINT;
               end else begin
                  res[0] = qtt_pkg::make_item(qtt_pkg::KIND_ERR, 8'd0, 1'b0, 1'b1, 1'b1,
                                              token_start_ff, qtt_pkg::ERR_CHAR);
                  res_cnt = 2'd1;
                  held_valid_in = 1'b0;
                  mode_in = qtt_pkg::MODE_ERR;
               end
            end
            qtt_pkg::MODE_PSYM: begin
               if (qtt_pkg::is_pair(held_byte_ff, c)) begin
                  res[0] = qtt_pkg::make_item(held_kind_ff, held_byte_ff, 1'b1,
                                              held_first_ff, 1'b0, token_start_ff,
                                              qtt_pkg::ERR_NONE);
                  res[1] = qtt_pkg::make_item(qtt_pkg::KIND_SYM, c, 1'b1, 1'b0, 1'b1,
                                              token_start_ff, qtt_pkg::ERR_NONE);
                  res_cnt = 2'd2;
                  held_first_in = 1'b0;
                  mode_in = qtt_pkg::MODE_IDLE;
               end else if (qtt_pkg::is_single(held_byte_ff)) begin
                  res[0] = qtt_pkg::make_item(held_kind_ff, held_byte_ff, 1'b1,
                                              held_first_ff, 1'b1, token_start_ff,
                                              qtt_pkg::ERR_NONE);
                  res_cnt = 2'd1;
                  held_first_in = 1'b0;
                  held_valid_in = 1'b0;
                  do_start = 1'b1;
               end else begin
                  res[0] = qtt_pkg::make_item(qtt_pkg::KIND_ERR, 8'd0, 1'b0, 1'b1, 1'b1,
                                              token_start_ff, qtt_pkg::ERR_CHAR);
                  res_cnt = 2'd1;
                  held_valid_in = 1'b0;
                  mode_in = qtt_pkg::MODE_ERR;
               end
            end
            qtt_pkg::MODE_ERR: begin
            end
            default: begin
            end
         endcase

         if (do_start) begin
            mode_in = qtt_pkg::MODE_IDLE;
            token_start_in = pos_ff;
            if (qtt_pkg::is_space(c)) begin
            end else if (c == "/") begin
               mode_in = qtt_pkg::MODE_PSLASH;
            end else if (c == "-") begin
               mode_in = qtt_pkg::MODE_PMINUS;
            end else if (qtt_pkg::is_alpha(c) || c == "_") begin
               held_byte_in = c;
               held_valid_in = 1'b1;
               held_first_in = 1'b1;
               held_kind_in = qtt_pkg::KIND_IDENT;
               mode_in = qtt_pkg::MODE_IDENT;
            end else if (c == 8'h27 || c == 8'h22) begin
               quote_double_in = (c == 8'h22);
               held_valid_in = 1'b0;
               held_first_in = 1'b1;
               held_kind_in = qtt_pkg::KIND_STR;
               mode_in = qtt_pkg::MODE_STR;
            end else if (qtt_pkg::is_digit(c)) begin
               held_byte_in = c;
               held_valid_in = 1'b1;
               held_first_in = 1'b1;
               held_kind_in = qtt_pkg::KIND_NUM;
               mode_in = qtt_pkg::MODE_NINT;
            end else if (qtt_pkg::is_pair_start(c)) begin
               held_byte_in = c;
               held_valid_in = 1'b1;
               held_first_in = 1'b1;
               held_kind_in = qtt_pkg::KIND_SYM;
               mode_in = qtt_pkg::MODE_PSYM;
            end else if (qtt_pkg::is_single(c)) begin
               res[res_cnt[0]] = qtt_pkg::make_item(qtt_pkg::KIND_SYM, c, 1'b1, 1'b1, 1'b1,
                                                    pos_ff, qtt_pkg::ERR_NONE);
               res_cnt = res_cnt + 2'd1;
            end else begin
               res[res_cnt[0]] = qtt_pkg::make_item(qtt_pkg::KIND_ERR, 8'd0, 1'b0, 1'b1,
                                                    1'b1, pos_ff, qtt_pkg::ERR_CHAR);
               res_cnt = res_cnt + 2'd1;
               held_valid_in = 1'b0;
               mode_in = qtt_pkg::MODE_ERR;
            end
         end

         if (pos_ff != PosMax) pos_in = pos_ff + 1'b1;
      end

      res[0].run_last = (res_cnt == 2'd1);
      res[1].run_last = (res_cnt == 2'd2);
   end

   assign accept = req_ch.valid & req_ch.ready;
   assign pop = rsp_ch.valid & rsp_ch.ready;
   assign req_ch.ready = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_ch.ready);

   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      rd_in = rd_ff;
      if (accept) begin
         buf_in = res;
         cnt_in = res_cnt;
         rd_in = 1'b0;
      end else if (pop) begin
         cnt_in = cnt_ff - 2'd1;
         rd_in = rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff <= 1'b0;
         mode_ff <= qtt_pkg::MODE_IDLE;
         held_byte_ff <= 8'd0;
         held_valid_ff <= 1'b0;
         held_first_ff <= 1'b0;
         held_kind_ff <= 3'd0;
         token_start_ff <= '0;
         pos_ff <= '0;
         quote_double_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         if (accept) begin
            mode_ff <= mode_in;
            held_byte_ff <= held_byte_in;
            held_valid_ff <= held_valid_in;
            held_first_ff <= held_first_in;
            held_kind_ff <= held_kind_in;
            token_start_ff <= token_start_in;
            pos_ff <= pos_in;
            quote_double_ff <= quote_double_in;
         end
      end
   end

   assign rsp_ch.valid = (cnt_ff != 2'd0);
   assign rsp_ch.token_kind = buf_ff[rd_ff].token_kind;
   assign rsp_ch.data_byte = buf_ff[rd_ff].data_byte;
   assign rsp_ch.has_data = buf_ff[rd_ff].has_data;
   assign rsp_ch.token_first = buf_ff[rd_ff].token_first;
   assign rsp_ch.token_last = buf_ff[rd_ff].token_last;
   assign rsp_ch.token_offset = buf_ff[rd_ff].token_offset;
   assign rsp_ch.error_code = buf_ff[rd_ff].error_code;
   assign rsp_ch.run_last = buf_ff[rd_ff].run_last;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the query text tokenizer: byte stream in, token items out.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qtt_pkg::*;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 7;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 70;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES = 200;
   localparam int FULL_RATE_TEXTS = 3;

   logic clock = 1'b0;
   logic reset;

   qtt_req_if req_ch ();
   qtt_rsp_if rsp_ch ();

   query_text_tokenizer_top i_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // lexer state of the predictor
   mode_type lex_mode;
   logic [7:0] held_byte_q;
   logic held_valid_q;
   logic held_first_q;
   logic [2:0] held_kind_q;
   logic [15:0] tok_start;
   logic [15:0] text_pos;
   logic quote_double;

   item_type step_items[$];
   item_type expected_tokens[$];
   logic [7:0] text_buf[$];

   string lone_syms = "(){}[];,.=!<>:+";
   string pair_syms = "=>==!=<=>=&&||<>";
   string escape_picks = "nrt'\"\\q0";
   logic [7:0] blank_bytes[6] = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};

   bit sender_idles = 1'b1;
   bit receiver_idles = 1'b1;
   int hold_request = 0;
   int error_count = 0;
   int results_checked = 0;
   int bytes_sent = 0;
   int texts_sent = 0;

   function automatic logic is_blank(logic [7:0] c);
      foreach (blank_bytes[i]) if (blank_bytes[i] == c) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic is_num_char(logic [7:0] c);
      return c inside {["0":"9"]};
   endfunction

   function automatic logic is_letter(logic [7:0] c);
      return c inside {["a":"z"], ["A":"Z"]};
   endfunction

   function automatic logic is_name_char(logic [7:0] c);
      return is_letter(c) || is_num_char(c) || c == "_";
   endfunction

   function automatic logic is_lone_sym(logic [7:0] c);
      for (int i = 0; i < lone_syms.len(); i++) if (lone_syms[i] == c) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic is_sym_pair(logic [7:0] a, logic [7:0] b);
      for (int i = 0; i < pair_syms.len(); i += 2)
         if (pair_syms[i] == a && pair_syms[i + 1] == b) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic opens_pair(logic [7:0] c);
      return c inside {"=", "!", "<", ">", "&", "|"};
   endfunction

   function automatic logic [7:0] esc_value(logic [7:0] c);
      if (c == "n") return 8'd10;
      if (c == "r") return 8'd13;
      if (c == "t") return 8'd9;
      return c;
   endfunction

   function automatic mode_type number_mode_after(mode_type m, logic [7:0] c);
      logic d;
      logic e;
      d = is_num_char(c);
      e = (c == "e" || c == "E");
      case (m)
         MODE_NINT: return d ? MODE_NINT : (c == ".") ? MODE_NFRAC : e ? MODE_NEXP : MODE_IDLE;
         MODE_NFRAC: return d ? MODE_NFRAC : e ? MODE_NEXP : MODE_IDLE;
         MODE_NEXP: return (d || c == "+" || c == "-") ? MODE_NEXPD : MODE_IDLE;
         default: return d ? MODE_NEXPD : MODE_IDLE;
      endcase
   endfunction

   function automatic void add_result(logic [2:0] kind, logic [7:0] data, logic has,
                                      logic first, logic last, logic [15:0] off,
                                      logic [1:0] err);
      item_type r;
      r.token_kind = kind;
      r.data_byte = has ? data : 8'd0;
      r.has_data = has;
      r.token_first = first;
      r.token_last = last;
      r.token_offset = off;
      r.error_code = err;
      r.run_last = 1'b0;
      if (step_items.size() < 3) step_items = {step_items, r};
   endfunction

   function automatic void flush_held(logic last);
      add_result(held_kind_q, held_byte_q, 1'b1, held_first_q, last, tok_start, ERR_NONE);
      held_first_q = 1'b0;
      if (last) held_valid_q = 1'b0;
   endfunction

   function automatic void latch_byte(logic [7:0] c, logic [2:0] kind);
      held_byte_q = c;
      held_valid_q = 1'b1;
      held_first_q = 1'b1;
      held_kind_q = kind;
   endfunction

   function automatic void append_byte(logic [7:0] c);
      if (held_valid_q) flush_held(1'b0);
      held_byte_q = c;
      held_valid_q = 1'b1;
   endfunction

   function automatic void raise_error(logic [1:0] code, logic [15:0] off);
      add_result(KIND_ERR, 8'd0, 1'b0, 1'b1, 1'b1, off, code);
      held_valid_q = 1'b0;
      lex_mode = MODE_ERR;
   endfunction

   function automatic void open_token(logic [7:0] c, logic [15:0] pos);
      lex_mode = MODE_IDLE;
      tok_start = pos;
      if (is_blank(c)) return;
      if (c == "/") begin
         lex_mode = MODE_PSLASH;
      end else if (c == "-") begin
         lex_mode = MODE_PMINUS;
      end else if (is_letter(c) || c == "_") begin
         latch_byte(c, KIND_IDENT);
         lex_mode = MODE_IDENT;
      end else if (c == "'" || c == "\"") begin
         quote_double = (c == "\"");
         held_valid_q = 1'b0;
         held_first_q = 1'b1;
         held_kind_q = KIND_STR;
         lex_mode = MODE_STR;
      end else if (is_num_char(c)) begin
         latch_byte(c, KIND_NUM);
         lex_mode = MODE_NINT;
      end else if (opens_pair(c)) begin
         latch_byte(c, KIND_SYM);
         lex_mode = MODE_PSYM;
      end else if (is_lone_sym(c)) begin
         add_result(KIND_SYM, c, 1'b1, 1'b1, 1'b1, pos, ERR_NONE);
      end else begin
         raise_error(ERR_CHAR, pos);
      end
   endfunction

   function automatic void lex_byte(logic [7:0] c, logic [15:0] pos);
      mode_type nm;
      logic [7:0] closer;
      closer = quote_double ? "\"" : "'";
      case (lex_mode)
         MODE_IDLE: open_token(c, pos);
         MODE_IDENT: begin
            if (is_name_char(c)) begin
               append_byte(c);
            end else begin
               flush_held(1'b1);
               open_token(c, pos);
            end
         end
         MODE_NINT, MODE_NFRAC, MODE_NEXP, MODE_NEXPD: begin
            nm = number_mode_after(lex_mode, c);
            if (nm != MODE_IDLE) begin
               append_byte(c);
               lex_mode = nm;
            end else begin
               flush_held(1'b1);
               open_token(c, pos);
            end
         end
         MODE_STR: begin
            if (c == closer) begin
               if (held_valid_q) flush_held(1'b1);
               else add_result(KIND_STR, 8'd0, 1'b0, 1'b1, 1'b1, tok_start, ERR_NONE);
               held_valid_q = 1'b0;
               lex_mode = MODE_IDLE;
            end else if (c == "\\") begin
               lex_mode = MODE_STRESC;
            end else begin
               append_byte(c);
            end
         end
         MODE_STRESC: begin
            append_byte(esc_value(c));
            lex_mode = MODE_STR;
         end
         MODE_LINE: if (c == "\n") lex_mode = MODE_IDLE;
         MODE_BLOCK: if (c == "*") lex_mode = MODE_BSTAR;
         MODE_BSTAR: begin
            if (c == "/") lex_mode = MODE_IDLE;
            else if (c != "*") lex_mode = MODE_BLOCK;
         end
         MODE_PSLASH: begin
            if (c == "/") lex_mode = MODE_LINE;
            else if (c == "*") lex_mode = MODE_BLOCK;
            else raise_error(ERR_CHAR, tok_start);
         end
         MODE_PMINUS: begin
            if (c == "-") begin
               lex_mode = MODE_LINE;
            end else if (is_num_char(c)) begin
               add_result(KIND_NUM, "-", 1'b1, 1'b1, 1'b0, tok_start, ERR_NONE);
               latch_byte(c, KIND_NUM);
               held_first_q = 1'b0;
               lex_mode = MODE_NINT;
            end else begin
               raise_error(ERR_CHAR, tok_start);
            end
         end
         MODE_PSYM: begin
            if (is_sym_pair(held_byte_q, c)) begin
               flush_held(1'b0);
               add_result(KIND_SYM, c, 1'b1, 1'b0, 1'b1, tok_start, ERR_NONE);
               lex_mode = MODE_IDLE;
            end else if (is_lone_sym(held_byte_q)) begin
               flush_held(1'b1);
               open_token(c, pos);
            end else begin
               raise_error(ERR_CHAR, tok_start);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void lex_end();
      case (lex_mode)
         MODE_IDENT, MODE_NINT, MODE_NFRAC, MODE_NEXP, MODE_NEXPD: begin
            flush_held(1'b1);
            add_result(KIND_END, 8'd0, 1'b0, 1'b1, 1'b1, text_pos, ERR_NONE);
         end
         MODE_STR, MODE_STRESC:
            add_result(KIND_ERR, 8'd0, 1'b0, 1'b1, 1'b1, tok_start, ERR_STRING);
         MODE_BLOCK, MODE_BSTAR:
            add_result(KIND_ERR, 8'd0, 1'b0, 1'b1, 1'b1, tok_start, ERR_COMMENT);
         MODE_PSLASH, MODE_PMINUS:
            add_result(KIND_ERR, 8'd0, 1'b0, 1'b1, 1'b1, tok_start, ERR_CHAR);
         MODE_PSYM: begin
            if (is_lone_sym(held_byte_q)) begin
               flush_held(1'b1);
               add_result(KIND_END, 8'd0, 1'b0, 1'b1, 1'b1, text_pos, ERR_NONE);
            end else begin
               add_result(KIND_ERR, 8'd0, 1'b0, 1'b1, 1'b1, tok_start, ERR_CHAR);
            end
         end
         MODE_IDLE, MODE_LINE:
            add_result(KIND_END, 8'd0, 1'b0, 1'b1, 1'b1, text_pos, ERR_NONE);
         default: ;
      endcase
   endfunction

   function automatic void lex_clear();
      lex_mode = MODE_IDLE;
      held_byte_q = 8'd0;
      held_valid_q = 1'b0;
      held_first_q = 1'b0;
      held_kind_q = KIND_IDENT;
      tok_start = 16'd0;
      text_pos = 16'd0;
      quote_double = 1'b0;
   endfunction

   function automatic void predict_tokens(logic act, logic [7:0] c);
      logic [15:0] pos;
      step_items.delete();
      if (act == ACTION_END) begin
         lex_end();
         lex_clear();
      end else begin
         pos = text_pos;
         lex_byte(c, pos);
         if (pos != 16'hFFFF) text_pos = pos + 16'd1;
      end
      if (step_items.size() != 0) step_items[step_items.size() - 1].run_last = 1'b1;
      expected_tokens = {expected_tokens, step_items};
   endfunction

   task automatic send_item(logic act, logic [7:0] c);
      if (sender_idles && $urandom_range(99) < 27) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= act;
      req_ch.char_in <= c;
      @(negedge clock);
      while (!req_ch.ready) @(negedge clock);
      @(posedge clock);
      bytes_sent++;
      predict_tokens(act, c);
   endtask

   task automatic send_end();
      send_item(ACTION_END, 8'($urandom_range(255)));
      texts_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(ACTION_CHAR, s[i]);
   endtask

   function automatic void put_byte(logic [7:0] b);
      text_buf.insert(text_buf.size(), b);
   endfunction

   function automatic logic [7:0] pick_name_char();
      case ($urandom_range(3))
         0: return 8'("a" + $urandom_range(25));
         1: return 8'("A" + $urandom_range(25));
         2: return 8'("0" + $urandom_range(9));
         default: return "_";
      endcase
   endfunction

   function automatic void add_digits(int lo, int hi);
      repeat ($urandom_range(lo, hi)) put_byte(8'("0" + $urandom_range(9)));
   endfunction

   function automatic void add_ident();
      logic [7:0] b;
      b = pick_name_char();
      if (is_num_char(b)) b = "_";
      put_byte(b);
      repeat ($urandom_range(6)) put_byte(pick_name_char());
   endfunction

   function automatic void add_number();
      if ($urandom_range(1) != 0) put_byte("-");
      add_digits(1, 4);
      if ($urandom_range(2) == 0) begin
         put_byte(".");
         add_digits(0, 3);
      end
      if ($urandom_range(3) == 0) begin
         put_byte(($urandom_range(1) != 0) ? "e" : "E");
         case ($urandom_range(2))
            0: put_byte("+");
            1: put_byte("-");
            default: ;
         endcase
         add_digits(0, 2);
      end
   endfunction

   function automatic void add_quoted(logic closed);
      logic [7:0] q;
      logic [7:0] b;
      q = ($urandom_range(1) != 0) ? "\"" : "'";
      put_byte(q);
      repeat ($urandom_range(5)) begin
         if ($urandom_range(3) == 0) begin
            put_byte("\\");
            put_byte(escape_picks[$urandom_range(escape_picks.len() - 1)]);
         end else begin
            b = 8'($urandom_range(255));
            if (b == q || b == "\\") b = ".";
            put_byte(b);
         end
      end
      if (closed) put_byte(q);
   endfunction

   function automatic void add_symbol();
      int k;
      if ($urandom_range(4) < 3) begin
         put_byte(lone_syms[$urandom_range(lone_syms.len() - 1)]);
      end else begin
         k = 2 * $urandom_range(7);
         put_byte(pair_syms[k]);
         put_byte(pair_syms[k + 1]);
      end
   endfunction

   function automatic void add_blanks();
      repeat ($urandom_range(1, 2)) put_byte(blank_bytes[$urandom_range(5)]);
   endfunction

   function automatic void add_line_comment(logic closed);
      logic [7:0] b;
      b = ($urandom_range(1) != 0) ? "/" : "-";
      put_byte(b);
      put_byte(b);
      repeat ($urandom_range(6)) begin
         b = 8'($urandom_range(255));
         if (b == "\n") b = "#";
         put_byte(b);
      end
      if (closed) put_byte("\n");
   endfunction

   function automatic void add_block_comment(logic closed);
      logic [7:0] b;
      put_byte("/");
      put_byte("*");
      repeat ($urandom_range(6)) begin
         b = ($urandom_range(2) == 0) ? "*" : 8'($urandom_range(255));
         if (b == "/") b = "*";
         put_byte(b);
      end
      if (closed) begin
         put_byte("*");
         put_byte("/");
      end
   endfunction

   task automatic send_random_text();
      int pick;
      text_buf.delete();
      repeat ($urandom_range(2, 10)) begin
         pick = $urandom_range(99);
         if (pick < 20) add_ident();
         else if (pick < 38) add_number();
         else if (pick < 52) add_quoted(1'b1);
         else if (pick < 68) add_symbol();
         else if (pick < 77) add_line_comment(1'b1);
         else if (pick < 86) add_block_comment(1'b1);
         else if (pick < 96) add_blanks();
         else put_byte(8'($urandom_range(255)));
         if ($urandom_range(3) != 0) add_blanks();
      end
      case ($urandom_range(11))
         0: add_quoted(1'b0);
         1: add_block_comment(1'b0);
         2: add_line_comment(1'b0);
         default: ;
      endcase
      foreach (text_buf[i]) send_item(ACTION_CHAR, text_buf[i]);
      send_end();
   endtask

   task automatic test_bad_bytes();
      send_item(ACTION_CHAR, 8'h00);
      send_item(ACTION_CHAR, 8'hFF);
      send_end();
      send_item(ACTION_CHAR, 8'hFF);
      send_end();
   endtask

   task automatic test_lone_symbols();
      send_text("&");
      send_end();
      send_text("-x");
      send_end();
      send_text("-");
      send_end();
      send_text("/");
      send_end();
      send_text("|");
      send_end();
   endtask

   task automatic test_open_ends();
      send_text("'\\q\\");
      send_end();
      send_text("/*");
      send_end();
   endtask

   task automatic test_full_rate();
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      repeat (FULL_RATE_TEXTS) send_random_text();
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
   endtask

   task automatic test_random_texts();
      int start;
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_ITEMS) send_random_text();
   endtask

   task automatic test_output_backpressure();
      sender_idles = 1'b0;
      hold_request = HOLD_CYCLES;
      send_random_text();
      send_random_text();
      sender_idles = 1'b1;
   endtask

   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !(receiver_idles && $urandom_range(99) < 27);
         end
      end
   end

   function automatic void report_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got)
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
   endfunction

   always @(negedge clock) begin
      item_type want;
      item_type got;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
         got.token_kind = rsp_ch.token_kind;
         got.data_byte = rsp_ch.data_byte;
         got.has_data = rsp_ch.has_data;
         got.token_first = rsp_ch.token_first;
         got.token_last = rsp_ch.token_last;
         got.token_offset = rsp_ch.token_offset;
         got.error_code = rsp_ch.error_code;
         got.run_last = rsp_ch.run_last;
         if (expected_tokens.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
         end else begin
            want = expected_tokens.pop_front();
            results_checked++;
            if (got !== want) begin
               error_count++;
               report_field("token_kind", 16'(want.token_kind), 16'(got.token_kind));
               report_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
               report_field("has_data", 16'(want.has_data), 16'(got.has_data));
               report_field("token_first", 16'(want.token_first), 16'(got.token_first));
               report_field("token_last", 16'(want.token_last), 16'(got.token_last));
               report_field("token_offset", want.token_offset, got.token_offset);
               report_field("error_code", 16'(want.error_code), 16'(got.error_code));
               report_field("run_last", 16'(want.run_last), 16'(got.run_last));
            end
         end
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(negedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: timeout, no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("** query_text_tokenizer_top: FAILED **");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.action <= ACTION_CHAR;
      req_ch.char_in <= 8'd0;
      lex_clear();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_bad_bytes();
      test_lone_symbols();
      test_open_ends();
      test_full_rate();
      test_random_texts();
      test_output_backpressure();
      test_random_texts();
      req_ch.valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d byte/end transfers in %0d texts, checked %0d token results,",
               bytes_sent, texts_sent, results_checked);
      $display("including error recovery, full-rate stretches and a long output hold-off.");
      if (error_count == 0 && expected_tokens.size() == 0)
         $display("** query_text_tokenizer_top: PASSED **");
      else
         $display("** query_text_tokenizer_top: FAILED **");
      $finish;
   end

endmodule
